### rtl/bitonic_sort_64_descending_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the descending sort unit.
// Each macro expects a signal named clk and a signal named rst in scope.
// ---------------------------------------------------------------------------
`ifndef BITONIC_SORT_64_DESCENDING_UNIT_MACROS_SVH
`define BITONIC_SORT_64_DESCENDING_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bsd_pkg.sv
// ---------------------------------------------------------------------------
// bsd_pkg
// Shared types and defaults for the descending sort unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  // Default set size and word width.
  localparam int SORT_SIZE_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 16;

  // Controller states: collecting words, or draining the sorted set.
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Per-cycle command broadcast from the controller to every cell.
  typedef struct packed {
    logic insert;  // place the incoming word into the sorted chain
    logic shift;   // move every cell one place toward the output
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/bsd_cell.sv
// ---------------------------------------------------------------------------
// bsd_cell
// One slot of the sorting chain. It holds one word and a valid bit, and on
// an insert either keeps its word, takes the new word, or takes its upper
// neighbor's word; on a shift it takes its lower neighbor's word.
// ---------------------------------------------------------------------------
`default_nettype none

module bsd_cell #(
  parameter int DATA_WIDTH = bsd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bsd_pkg::cell_cmd_t    cmd,
  input  wire logic [DATA_WIDTH-1:0] new_value,
  input  wire logic [DATA_WIDTH-1:0] prev_value,
  input  wire logic                  prev_valid,
  input  wire logic                  prev_ins,
  input  wire logic [DATA_WIDTH-1:0] next_value,
  input  wire logic                  next_valid,
  output logic      [DATA_WIDTH-1:0] data,
  output logic                       valid,
  output logic                       ins
);

  import bsd_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;
  logic                  valid_next;

  // The new word belongs at or above this slot when the slot is empty or
  // holds a smaller word. The chain stays sorted largest first.
  assign ins = !valid || (new_value > data);

  // Select the slot's next content.
  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (cmd.shift) begin
      data_next  = next_value;
      valid_next = next_valid;
    end else if (cmd.insert && ins) begin
      if (prev_ins) begin
        // The slot above also moves down, so take its word.
        data_next  = prev_value;
        valid_next = prev_valid;
      end else begin
        // This is the insertion point.
        data_next  = new_value;
        valid_next = 1'b1;
      end
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // The word itself needs no reset.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

### rtl/bsd_ctrl.sv
// ---------------------------------------------------------------------------
// bsd_ctrl
// Sequencer for the sort unit: counts words of a set as they load, then
// drives the drain of the sorted set and flags its final word.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitonic_sort_64_descending_unit_macros.svh"

module bsd_ctrl #(
  parameter int SORT_SIZE = bsd_pkg::SORT_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    strobe,
  output logic                    last,
  output bsd_pkg::cell_cmd_t      cmd
);

  import bsd_pkg::*;

  localparam int CNT_W = (SORT_SIZE > 1) ? $clog2(SORT_SIZE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SORT_SIZE - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             accept;

  assign accept = start && !busy;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
    end
  end

  // Next state and outputs. The same counter tracks loaded words and then
  // emitted words.
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    busy            = 1'b0;
    strobe          = 1'b0;
    last            = 1'b0;
    cmd.insert      = 1'b0;
    cmd.shift       = 1'b0;
    unique case (state)
      ST_LOAD: begin
        cmd.insert = start;
        if (start) begin
          if (fill_count == CNT_LAST) begin
            fill_count_next = '0;
            state_next      = ST_EMIT;
          end else begin
            fill_count_next = fill_count + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        busy      = 1'b1;
        strobe    = 1'b1;
        cmd.shift = 1'b1;
        if (fill_count == CNT_LAST) begin
          last            = 1'b1;
          fill_count_next = '0;
          state_next      = ST_LOAD;
        end else begin
          fill_count_next = fill_count + 1'b1;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // A completed set starts draining right away.
  `BSD_ASSERT_NEXT(a_full_set_drains, accept && (fill_count == CNT_LAST), strobe, "set did not drain")
  // Once a drain has begun it runs without gaps until the last word.
  `BSD_ASSERT_NEXT(a_drain_contiguous, strobe && !last, strobe, "gap in drain")
  // After the last word the unit takes input again.
  `BSD_ASSERT_NEXT(a_ready_after_last, last, !busy && !strobe, "not ready after last word")

endmodule

`default_nettype wire

### rtl/bitonic_sort_64_descending_unit.sv
// ---------------------------------------------------------------------------
// bitonic_sort_64_descending_unit
// Sorts sets of SORT_SIZE unsigned words and returns each set largest first.
// ---------------------------------------------------------------------------
// Words enter one per cycle while busy is low: a word is taken on each rising
// edge with start high and busy low. Each word is placed into a chain of
// SORT_SIZE cells that keeps the collected words in descending order, so a
// set is already sorted when its final word lands. On the following cycle
// busy rises and the chain shifts toward the output until the set is out,
// presenting one word per cycle on sorted_value with strobe high, and last
// high on the final word. The receiver cannot stall; it must take each word
// in its strobe cycle. Equal words may come out in any order.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitonic_sort_64_descending_unit_macros.svh"

module bitonic_sort_64_descending_unit #(
  parameter int SORT_SIZE  = bsd_pkg::SORT_SIZE_DEF,
  parameter int DATA_WIDTH = bsd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0]      sorted_value,
  output logic                       last,
  output logic                       strobe
);

  import bsd_pkg::*;

  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_data  [SORT_SIZE];
  logic                  cell_valid [SORT_SIZE];
  logic                  cell_ins   [SORT_SIZE];

  // Sequencer.
  bsd_ctrl #(
    .SORT_SIZE (SORT_SIZE)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .last   (last),
    .cmd    (cmd)
  );

  // Chain of cells; cell 0 holds the largest word and feeds the output.
  for (genvar i = 0; i < SORT_SIZE; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_value;
    logic                  prev_valid;
    logic                  prev_ins;
    logic [DATA_WIDTH-1:0] next_value;
    logic                  next_valid;

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_valid = 1'b0;
      assign prev_ins   = 1'b0;
    end else begin : g_body
      assign prev_value = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ins   = cell_ins[i-1];
    end

    if (i == SORT_SIZE - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    bsd_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_value  (value),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .prev_ins   (prev_ins),
      .next_value (next_value),
      .next_valid (next_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .ins        (cell_ins[i])
    );

    if (i > 0) begin : g_chk
      // Occupied cells form an unbroken run from the head of the chain.
      `BSD_ASSERT_NOW(a_valid_packed, cell_valid[i], cell_valid[i-1], "hole in cell chain")
      // The chain stays sorted largest first.
      `BSD_ASSERT_NOW(a_descending, cell_valid[i], cell_data[i-1] >= cell_data[i], "chain out of order")
    end
  end

  // Output word comes straight from the head cell.
  assign sorted_value = cell_data[0];

  // Every emitted word comes from an occupied head cell.
  `BSD_ASSERT_NOW(a_emit_valid, strobe, cell_valid[0], "emitting from empty chain")

endmodule

`default_nettype wire
